/* hw/rtl/bsa_pkg.sv */
package bsa_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = SLOT_COUNT / WORD_BITS;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WIDX_W = $clog2(WORD_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    localparam int CMD_W    = 2;
    localparam int FSLOT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 9;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [WIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [WIDX_W-1:0] wr_addr;
        word_t             wr_data;
    } store_req_t;

    // lowest set bit
    function automatic logic [BIT_W-1:0] first_set(input word_t w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/bsa_req_if.sv */
interface bsa_req_if
    import bsa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [FSLOT_W-1:0] slot;

    modport source (output valid, output cmd, output slot, input ready);
    modport sink   (input valid, input cmd, input slot, output ready);
endinterface

/* hw/rtl/bsa_rsp_if.sv */
interface bsa_rsp_if
    import bsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FSLOT_W-1:0]  granted_slot;
    logic                occupied;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live_count;

    modport source (output valid, output granted_slot, output occupied, output status,
                    output live_count, input ready);
    modport sink   (input valid, input granted_slot, input occupied, input status,
                    input live_count, output ready);
endinterface

/* hw/rtl/bsa_ram.sv */
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bsa_store.sv */
module bsa_store
    import bsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output word_t      rd_word
);

    logic [WORD_COUNT-1:0] written_reg;
    logic                  rd_written_reg;
    word_t                 ram_data;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk     (clk),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_data),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data)
    );

    // words never written since reset read as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_word = rd_written_reg ? ram_data : '0;

endmodule

/* hw/rtl/bsa_ctrl.sv */
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsa_req_if.sink    req,
    bsa_rsp_if.source  rsp,
    output store_req_t store,
    input  word_t      rd_word
);

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [FSLOT_W-1:0]  slot_reg, slot_next;
    logic [WIDX_W-1:0]   word_reg, word_next;
    logic [CNT_W-1:0]    hint_reg, hint_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic [FSLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic                out_occ_reg, out_occ_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                accept;
    logic                out_free;
    logic                slot_in_range;
    logic [WIDX_W-1:0]   slot_word;
    logic [BIT_W-1:0]    slot_bit;
    logic                slot_used;
    logic [WIDX_W-1:0]   hint_word;
    logic [BIT_W-1:0]    hint_bit;
    logic                hint_full;
    word_t               scan_mask;
    word_t               free_bits;
    logic [BIT_W-1:0]    free_bit;
    logic [CNT_W-1:0]    alloc_idx;
    logic [CNT_W-1:0]    slot_ext;
    logic                finish;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign slot_ext      = CNT_W'(slot_reg);
    assign slot_in_range = slot_ext < CNT_W'(SLOT_COUNT);
    assign slot_word     = WIDX_W'(slot_reg >> BIT_W);
    assign slot_bit      = slot_reg[BIT_W-1:0];
    assign slot_used     = slot_in_range && rd_word[slot_bit];

    assign hint_word = hint_reg[SLOT_W-1:BIT_W];
    assign hint_bit  = hint_reg[BIT_W-1:0];
    assign hint_full = hint_reg == CNT_W'(SLOT_COUNT);
    assign scan_mask = (word_reg == hint_word) ? ~((word_t'(1) << hint_bit) - word_t'(1))
                                               : '1;
    assign free_bits = ~rd_word & scan_mask;
    assign free_bit  = first_set(free_bits);
    assign alloc_idx = CNT_W'({word_reg, free_bit});

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        slot_next       = slot_reg;
        word_next       = word_reg;
        hint_next       = hint_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_occ_next    = out_occ_reg;
        out_status_next = out_status_reg;
        store           = '0;
        finish          = 1'b0;
        req.ready       = state_reg == ST_IDLE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = req.cmd;
                    slot_next = req.slot;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        word_next = hint_word;
                    end
                    else
                    begin
                        word_next = WIDX_W'(req.slot >> BIT_W);
                    end
                    store.rd_en   = 1'b1;
                    store.rd_addr = word_next;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (hint_full)
                        begin
                            finish          = 1'b1;
                            out_slot_next   = '0;
                            out_occ_next    = 1'b0;
                            out_status_next = STATUS_FULL;
                        end
                        else if (|free_bits)
                        begin
                            finish = 1'b1;
                            if (out_free)
                            begin
                                store.wr_en   = 1'b1;
                                store.wr_addr = word_reg;
                                store.wr_data = rd_word | (word_t'(1) << free_bit);
                                count_next    = count_reg + CNT_W'(1);
                                hint_next     = alloc_idx + CNT_W'(1);
                            end
                            out_slot_next   = FSLOT_W'(alloc_idx);
                            out_occ_next    = 1'b1;
                            out_status_next = STATUS_OK;
                        end
                        else if (word_reg == WIDX_W'(WORD_COUNT - 1))
                        begin
                            finish          = 1'b1;
                            out_slot_next   = '0;
                            out_occ_next    = 1'b0;
                            out_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            word_next     = word_reg + WIDX_W'(1);
                            store.rd_en   = 1'b1;
                            store.rd_addr = word_next;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        finish        = 1'b1;
                        out_slot_next = slot_reg;
                        out_occ_next  = 1'b0;
                        if (slot_used)
                        begin
                            if (out_free)
                            begin
                                store.wr_en   = 1'b1;
                                store.wr_addr = slot_word;
                                store.wr_data = rd_word & ~(word_t'(1) << slot_bit);
                                count_next    = count_reg - CNT_W'(1);
                                if (slot_ext < hint_reg)
                                begin
                                    hint_next = slot_ext;
                                end
                            end
                            out_status_next = STATUS_OK;
                        end
                        else
                        begin
                            out_status_next = STATUS_NOT_IN_USE;
                        end
                    end
                    default:
                    begin
                        finish          = 1'b1;
                        out_slot_next   = slot_reg;
                        out_occ_next    = slot_used;
                        out_status_next = STATUS_OK;
                    end
                endcase

                // hold the read word until the output register can take the result
                if (finish)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_slot_next   = out_slot_reg;
                        out_occ_next    = out_occ_reg;
                        out_status_next = out_status_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hint_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        slot_reg       <= slot_next;
        word_reg       <= word_next;
        out_slot_reg   <= out_slot_next;
        out_occ_reg    <= out_occ_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_slot = out_slot_reg;
    assign rsp.occupied     = out_occ_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.live_count   = LIVE_W'(count_reg);

endmodule

/* hw/rtl/bitmap_slot_allocator_top.sv */
// Slot allocator over a bitmap of used flags, one bit per slot, kept in a small
// synchronous RAM of 32-bit words with a search hint and a live count in registers.
// Each request transaction (allocate, release or query) yields exactly one response
// transaction carrying the slot, its occupancy, a status and the live count.
// Release and query read one RAM word after acceptance and write the result to the
// response register; allocate walks up to 8 words through the single RAM read port,
// one word a cycle from the hint, and stops at the first free bit. A new request is
// taken once the previous one has reached the response register, while that
// response may still be waiting. The bitmap needs no clearing pass after reset:
// words never written read as all free.
module bitmap_slot_allocator_top
    import bsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bsa_req_if.sink   req,
    bsa_rsp_if.source rsp
);

    store_req_t store;
    word_t      rd_word;

    bsa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .store   (store),
        .rd_word (rd_word)
    );

    bsa_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store),
        .rd_word (rd_word)
    );

endmodule

/* tb/tb_bitmap_slot_allocator_top.sv */
module tb_bitmap_slot_allocator_top
    import bsa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_QUERY_ALT = 2'd3;
    localparam int IDLE_PCT     = 19;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] used;
        logic [LIVE_W-1:0]     hint;
        logic [LIVE_W-1:0]     count;
    } slot_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FSLOT_W-1:0] slot;
    } slot_req_t;

    typedef struct packed {
        logic [FSLOT_W-1:0]  granted_slot;
        logic                occupied;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live_count;
    } slot_rsp_t;

    logic clk;
    logic rst_n;

    bsa_req_if req_ch ();
    bsa_rsp_if rsp_ch ();

    slot_state_t model_state;
    slot_state_t plan_state;
    slot_req_t   req_backlog[$];
    slot_rsp_t   rsp_expected[$];

    bit          req_taken;
    int unsigned cycle_cnt;
    int unsigned sent_cnt;
    int unsigned rsp_cnt;
    int unsigned errors;

    bitmap_slot_allocator_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic slot_rsp_t apply_slot_cmd(inout slot_state_t st, input slot_req_t rq);
        slot_rsp_t   r;
        int unsigned idx;
        r.granted_slot = rq.slot;
        r.occupied     = 1'b0;
        r.status       = STATUS_OK;
        if (rq.cmd == CMD_ALLOC)
        begin
            idx = st.hint;
            while (idx < SLOT_COUNT && st.used[idx])
            begin
                idx++;
            end
            if (idx >= SLOT_COUNT)
            begin
                r.granted_slot = '0;
                r.status       = STATUS_FULL;
            end
            else
            begin
                st.used[idx]   = 1'b1;
                st.count       = st.count + 1'b1;
                st.hint        = LIVE_W'(idx + 1);
                r.granted_slot = FSLOT_W'(idx);
                r.occupied     = 1'b1;
            end
        end
        else if (rq.cmd == CMD_RELEASE)
        begin
            if (!st.used[rq.slot])
            begin
                r.status = STATUS_NOT_IN_USE;
            end
            else
            begin
                st.used[rq.slot] = 1'b0;
                if (LIVE_W'(rq.slot) < st.hint)
                begin
                    st.hint = LIVE_W'(rq.slot);
                end
                st.count = st.count - 1'b1;
            end
        end
        else
        begin
            r.occupied = st.used[rq.slot];
        end
        r.live_count = st.count;
        return r;
    endfunction

    // mostly a slot in use, so that releases and queries hit real entries
    function automatic logic [FSLOT_W-1:0] pick_used_slot(input slot_state_t st);
        int unsigned start;
        int unsigned s;
        start = $urandom_range(SLOT_COUNT - 1);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            s = (start + i) % SLOT_COUNT;
            if (st.used[s])
            begin
                return FSLOT_W'(s);
            end
        end
        return FSLOT_W'(start);
    endfunction

    task automatic add_req(input logic [CMD_W-1:0] c, input logic [FSLOT_W-1:0] s);
        slot_req_t rq;
        rq.cmd  = c;
        rq.slot = s;
        void'(apply_slot_cmd(plan_state, rq));
        req_backlog.push_back(rq);
    endtask

    task automatic add_random_mix(input int n, input int alloc_pct, input int release_pct);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < alloc_pct)
            begin
                add_req(CMD_ALLOC, FSLOT_W'($urandom_range(255)));
            end
            else if (r < alloc_pct + release_pct)
            begin
                add_req(CMD_RELEASE, ($urandom_range(9) == 0) ? FSLOT_W'($urandom_range(255))
                                                              : pick_used_slot(plan_state));
            end
            else
            begin
                add_req(($urandom_range(1) == 0) ? CMD_QUERY : CMD_QUERY_ALT,
                        ($urandom_range(1) == 0) ? FSLOT_W'($urandom_range(255))
                                                 : pick_used_slot(plan_state));
            end
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // monitor: request acceptance feeds the predictor, responses are checked in order
    always @(posedge clk)
    begin
        slot_rsp_t got;
        slot_rsp_t want;
        slot_req_t taken;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            req_taken = rst_n && req_ch.valid && req_ch.ready;
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_cnt++;
                got.granted_slot = rsp_ch.granted_slot;
                got.occupied     = rsp_ch.occupied;
                got.status       = rsp_ch.status;
                got.live_count   = rsp_ch.live_count;
                if (rsp_expected.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    check_field("granted_slot", want.granted_slot, got.granted_slot);
                    check_field("occupied", want.occupied, got.occupied);
                    check_field("status", want.status, got.status);
                    check_field("live_count", want.live_count, got.live_count);
                end
            end
            if (req_taken)
            begin
                taken.cmd  = req_ch.cmd;
                taken.slot = req_ch.slot;
                rsp_expected.push_back(apply_slot_cmd(model_state, taken));
            end
        end
    end

    // driver: request side from the backlog, response side back-pressure
    always @(negedge clk)
    begin
        slot_req_t nxt;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (req_backlog.size() != 0 &&
                    ((sent_cnt >= 250 && sent_cnt < 350) || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = req_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.cmd   <= nxt.cmd;
                    req_ch.slot  <= nxt.slot;
                    sent_cnt++;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= (rsp_cnt >= 240 && rsp_cnt < 350) || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_ALLOC;
        req_ch.slot  = '0;
        rsp_ch.ready = 1'b0;
        model_state  = '0;
        plan_state   = '0;
        req_taken    = 1'b0;
        cycle_cnt    = 0;
        sent_cnt     = 0;
        rsp_cnt      = 0;
        errors       = 0;

        // empty table, releases of free slots, hint moving down and back up
        add_req(CMD_QUERY, 8'd0);
        add_req(CMD_RELEASE, 8'd0);
        add_req(CMD_RELEASE, 8'd255);
        add_req(CMD_ALLOC, 8'd255);
        add_req(CMD_ALLOC, 8'hAA);
        add_req(CMD_ALLOC, 8'h55);
        add_req(CMD_QUERY, 8'd1);
        add_req(CMD_QUERY_ALT, 8'd2);
        add_req(CMD_QUERY_ALT, 8'd3);
        add_req(CMD_RELEASE, 8'd1);
        add_req(CMD_ALLOC, 8'd0);
        add_req(CMD_RELEASE, 8'd0);
        add_req(CMD_RELEASE, 8'd0);
        add_req(CMD_QUERY, 8'd0);
        add_req(CMD_QUERY, 8'd255);
        add_req(CMD_QUERY, 8'hAA);
        add_req(CMD_QUERY_ALT, 8'h55);
        add_req(CMD_ALLOC, 8'd0);
        add_req(CMD_RELEASE, 8'd2);
        add_req(CMD_ALLOC, 8'd0);

        add_random_mix(160, 50, 30);

        // fill the table, then run into the full case
        while (plan_state.count < SLOT_COUNT)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_req(CMD_QUERY, FSLOT_W'($urandom_range(255)));
            end
            else
            begin
                add_req(CMD_ALLOC, FSLOT_W'($urandom_range(255)));
            end
        end
        repeat (3)
        begin
            add_req(CMD_ALLOC, FSLOT_W'($urandom_range(255)));
        end
        add_req(CMD_RELEASE, 8'd255);
        add_req(CMD_ALLOC, 8'd0);
        add_req(CMD_ALLOC, 8'd0);
        repeat (4)
        begin
            add_req(CMD_RELEASE, FSLOT_W'($urandom_range(255)));
            add_req(CMD_ALLOC, FSLOT_W'($urandom_range(255)));
            add_req(CMD_ALLOC, FSLOT_W'($urandom_range(255)));
        end

        add_random_mix(140, 35, 45);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (rsp_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
